FILE: rtl/core/b62e_pkg.sv
// ----------------------------------------------------------------------------
// b62e_pkg
// Shared constants, types and the digit-to-character map of the base-62
// identifier encoder.
// ----------------------------------------------------------------------------
package b62e_pkg;

   localparam int ID_BITS     = 31;
   localparam int MAX_DIGITS  = 6;
   localparam int RADIX       = 62;
   localparam int DIGIT_W     = $clog2(RADIX);
   localparam int SYMBOL_W    = 7;
   localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);

   // Reciprocal of the radix, scaled so that the truncated quotient is never
   // more than one below the true quotient for any ID_BITS-wide value.
   localparam int RECIP_EXTRA = 5;
   localparam int RECIP_SHIFT = ID_BITS + RECIP_EXTRA;
   localparam int PROD_W      = 2 * ID_BITS;
   localparam logic [127:0] RECIP_WIDE = (128'd1 << RECIP_SHIFT) / RADIX;
   localparam logic [ID_BITS-1:0] RECIP = RECIP_WIDE[ID_BITS-1:0];

   localparam logic [SYMBOL_W-1:0] CHAR_LOWER_A = 7'd97;
   localparam logic [SYMBOL_W-1:0] CHAR_LOWER_Z = 7'd122;
   localparam logic [SYMBOL_W-1:0] CHAR_UPPER_A = 7'd65;
   localparam logic [SYMBOL_W-1:0] CHAR_UPPER_Z = 7'd90;
   localparam logic [SYMBOL_W-1:0] CHAR_ZERO    = 7'd48;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE    = 7'd57;

   localparam logic [DIGIT_W-1:0] LETTERS = 6'd26;

   typedef struct packed {
      logic load;
      logic mul;
      logic fix;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic id_zero;
      logic div_done;
      logic cnt_zero;
   } status_type;

   function automatic logic [SYMBOL_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [SYMBOL_W-1:0] dx;
      dx = SYMBOL_W'(d);
      if (d < LETTERS) begin
         return CHAR_LOWER_A + dx;
      end else if (d < 2 * LETTERS) begin
         return CHAR_UPPER_A + dx - SYMBOL_W'(LETTERS);
      end else begin
         return CHAR_ZERO + dx - SYMBOL_W'(2 * LETTERS);
      end
   endfunction

endpackage

FILE: rtl/core/b62e_datapath.sv
// ----------------------------------------------------------------------------
// b62e_datapath
// Working value, reciprocal multiplier with remainder correction, digit
// stack and output character register.
// ----------------------------------------------------------------------------
module b62e_datapath import b62e_pkg::*; (
   input  logic                clock,
   input  logic [ID_BITS-1:0]  req_identifier,
   input  cmd_type             cmd,
   output status_type          status,
   output logic [SYMBOL_W-1:0] rsp_symbol,
   output logic                rsp_final_symbol
);

   logic [ID_BITS-1:0]  value_ff, value_in;
   logic [PROD_W-1:0]   product_ff, product_in;
   logic [DIGIT_W-1:0]  digits_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0]  digits_in [MAX_DIGITS];
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic                final_ff, final_in;

   logic [ID_BITS-1:0]  quot0;
   logic [ID_BITS-1:0]  times_radix;
   logic [ID_BITS-1:0]  rem0;
   logic                rem_high;
   logic [ID_BITS-1:0]  quot;
   logic [DIGIT_W-1:0]  digit;

   always_comb begin
      quot0       = ID_BITS'(product_ff >> RECIP_SHIFT);
      times_radix = (quot0 << 6) - (quot0 << 1);
      rem0        = value_ff - times_radix;
      rem_high    = rem0 >= ID_BITS'(RADIX);
      quot        = rem_high ? quot0 + ID_BITS'(1) : quot0;
      digit       = rem_high ? DIGIT_W'(rem0 - ID_BITS'(RADIX)) : DIGIT_W'(rem0);
   end

   always_comb begin
      value_in   = value_ff;
      product_in = product_ff;
      digits_in  = digits_ff;
      count_in   = count_ff;
      symbol_in  = symbol_ff;
      final_in   = final_ff;
      if (cmd.load) begin
         value_in = req_identifier;
         count_in = '0;
      end
      if (cmd.mul) begin
         product_in = PROD_W'(value_ff) * PROD_W'(RECIP);
      end
      if (cmd.fix) begin
         value_in     = quot;
         count_in     = count_ff + COUNT_W'(1);
         digits_in[0] = digit;
         for (int i = 1; i < MAX_DIGITS; i++) begin
            digits_in[i] = digits_ff[i-1];
         end
      end
      if (cmd.pop) begin
         symbol_in = digit_to_ascii(digits_ff[0]);
         final_in  = count_ff == COUNT_W'(1);
         count_in  = count_ff - COUNT_W'(1);
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            digits_in[i] = digits_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      product_ff <= product_in;
      digits_ff  <= digits_in;
      count_ff   <= count_in;
      symbol_ff  <= symbol_in;
      final_ff   <= final_in;
   end

   always_comb begin
      status.id_zero  = req_identifier == '0;
      status.div_done = (quot == '0) || (count_ff == COUNT_W'(MAX_DIGITS - 1));
      status.cnt_zero = count_ff == '0;
   end

   assign rsp_symbol       = symbol_ff;
   assign rsp_final_symbol = final_ff;

endmodule

FILE: rtl/core/b62e_ctrl.sv
// ----------------------------------------------------------------------------
// b62e_ctrl
// Sequencer of the encoder: accepts an identifier, runs the divide steps,
// then hands out the characters one beat at a time.
// ----------------------------------------------------------------------------
module b62e_ctrl import b62e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_FIX  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_SEND = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.id_zero) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = status.div_done ? ST_LOAD : ST_MUL;
         end
         ST_LOAD: begin
            cmd.pop  = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (status.cnt_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_SEND;

endmodule

FILE: rtl/core/base62_id_encoder.sv
// ----------------------------------------------------------------------------
// base62_id_encoder
// Encodes an unsigned identifier as base-62 ASCII characters, most
// significant digit first, with the last character of each run flagged.
//
// The request channel takes one identifier per beat; the response channel
// gives one character per beat, rsp_final_symbol high on the last one.
// An identifier of zero is consumed and produces no response beats.
// One item is in work at a time: req_ready is high only while idle.
// Each digit takes a multiply step of the shared reciprocal multiplier and
// a remainder-correction step; once all digits are found, the first
// character is registered and then presented on the response channel.
// A zero identifier leaves the sequencer in idle.
// When the receiver stalls, the current character is held on the outputs
// and the sequencer waits. Synchronous reset returns the sequencer to idle
// and drops any run in progress; no memory needs clearing.
// ----------------------------------------------------------------------------
module base62_id_encoder import b62e_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ID_BITS-1:0]  req_identifier,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SYMBOL_W-1:0] rsp_symbol,
   output logic                rsp_final_symbol
);

   cmd_type    cmd;
   status_type status;

   b62e_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   b62e_datapath u_datapath (
      .clock            (clock),
      .req_identifier   (req_identifier),
      .cmd              (cmd),
      .status           (status),
      .rsp_symbol       (rsp_symbol),
      .rsp_final_symbol (rsp_final_symbol)
   );

endmodule

FILE: rtl/core/b62e_checker.sv
// ----------------------------------------------------------------------------
// b62e_checker
// Port-level checks of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module b62e_checker import b62e_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [ID_BITS-1:0]  req_identifier,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SYMBOL_W-1:0] rsp_symbol,
   input logic                rsp_final_symbol
);

   // A stalled response beat keeps its character and flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol)
         && $stable(rsp_final_symbol))
      else $error("Stalled response beat changed.");

   // A zero identifier yields no response beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_identifier == '0 |=> !rsp_valid && req_ready)
      else $error("Zero identifier produced output or blocked input.");

   // A nonzero identifier occupies the block until its run is delivered.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_identifier != '0 |=> !req_ready)
      else $error("New identifier accepted during a run.");

   // Every character belongs to the alphabet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol >= CHAR_LOWER_A && rsp_symbol <= CHAR_LOWER_Z)
         || (rsp_symbol >= CHAR_UPPER_A && rsp_symbol <= CHAR_UPPER_Z)
         || (rsp_symbol >= CHAR_ZERO && rsp_symbol <= CHAR_NINE))
      else $error("Character outside the alphabet.");

   // After a character without the final flag is taken, the response channel stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_symbol |=> rsp_valid)
      else $error("Run ended without a final character.");

endmodule

bind base62_id_encoder b62e_checker u_b62e_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_identifier   (req_identifier),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_symbol       (rsp_symbol),
   .rsp_final_symbol (rsp_final_symbol)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the base-62 identifier encoder. Identifiers go in on the
// request channel, and the characters that come back are checked beat by
// beat against an encoding worked out in the bench.
// A directed set covers the digit-count and alphabet boundaries, zero and the
// largest identifier; random identifiers of every length follow. Both
// channels idle at random, and the sender three times waits for a full drain.
// ----------------------------------------------------------------------------
module tb;
   import b62e_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned RANDOM_IDS  = 500;

   typedef struct {
      logic [ID_BITS-1:0] id;
      bit                 drain_first;
   } id_item_type;

   typedef struct {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } b62_char_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [ID_BITS-1:0]  req_identifier   = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [SYMBOL_W-1:0] rsp_symbol;
   logic                rsp_final_symbol;

   id_item_type  id_backlog[$];
   b62_char_type expected_chars[$];
   int unsigned  ids_total    = 0;
   int unsigned  ids_accepted = 0;
   int unsigned  errors       = 0;
   int unsigned  send_gap     = 0;
   int unsigned  send_steady  = 0;
   int unsigned  rsp_stall    = 0;
   int unsigned  rsp_steady   = 0;
   int unsigned  quiet        = 0;
   logic         drv_valid;
   b62_char_type want;

   base62_id_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_identifier   (req_identifier),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_final_symbol (rsp_final_symbol)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Appends the characters of one identifier, most significant digit first.
   function automatic void queue_encoding(input logic [ID_BITS-1:0] id);
      logic [ID_BITS-1:0] rest;
      int unsigned        digs[MAX_DIGITS];
      int                 n;
      b62_char_type       c;
      rest = id;
      n = 0;
      while (rest != 0 && n < MAX_DIGITS) begin
         digs[n] = int'(rest % ID_BITS'(RADIX));
         rest = rest / ID_BITS'(RADIX);
         n++;
      end
      for (int k = n - 1; k >= 0; k--) begin
         if (digs[k] < 26) begin
            c.symbol = CHAR_LOWER_A + SYMBOL_W'(digs[k]);
         end else if (digs[k] < 52) begin
            c.symbol = CHAR_UPPER_A + SYMBOL_W'(digs[k] - 26);
         end else begin
            c.symbol = CHAR_ZERO + SYMBOL_W'(digs[k] - 52);
         end
         c.last = (k == 0);
         expected_chars.insert(expected_chars.size(), c);
      end
   endfunction

   // Mostly short gaps, a few long ones, and now and then a stretch of none.
   function automatic int unsigned idle_cycles(inout int unsigned steady);
      int unsigned r;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         steady = $urandom_range(20, 60);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_id(input logic [ID_BITS-1:0] id, input bit drain_first);
      id_item_type it;
      it.id = id;
      it.drain_first = drain_first;
      id_backlog.insert(id_backlog.size(), it);
      ids_total++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drv_valid = req_valid;
         if (req_valid && req_ready) begin
            queue_encoding(req_identifier);
            ids_accepted++;
            drv_valid = 1'b0;
         end
         if (!drv_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (id_backlog.size() > 0 &&
                         !(id_backlog[0].drain_first && expected_chars.size() != 0)) begin
               req_identifier <= id_backlog[0].id;
               void'(id_backlog.pop_front());
               drv_valid = 1'b1;
               send_gap = idle_cycles(send_steady);
            end
         end
         req_valid <= drv_valid;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, actual 0x%02h final %0b",
                        $time, rsp_symbol, rsp_final_symbol);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_symbol !== want.symbol) begin
                  errors++;
                  $display("%0t: symbol mismatch, expected 0x%02h actual 0x%02h",
                           $time, want.symbol, rsp_symbol);
               end
               if (rsp_final_symbol !== want.last) begin
                  errors++;
                  $display("%0t: final_symbol mismatch, expected %0b actual %0b",
                           $time, want.last, rsp_final_symbol);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = idle_cycles(rsp_steady);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      logic [ID_BITS-1:0] id;
      // Zero, digit-count boundaries, alphabet boundaries and bit patterns.
      add_id(ID_BITS'(0), 1'b0);
      add_id(ID_BITS'(1), 1'b0);
      add_id(ID_BITS'(25), 1'b0);
      add_id(ID_BITS'(26), 1'b0);
      add_id(ID_BITS'(51), 1'b0);
      add_id(ID_BITS'(52), 1'b0);
      add_id(ID_BITS'(61), 1'b0);
      add_id(ID_BITS'(62), 1'b0);
      add_id(ID_BITS'(3843), 1'b0);
      add_id(ID_BITS'(3844), 1'b0);
      add_id(ID_BITS'(238327), 1'b0);
      add_id(ID_BITS'(238328), 1'b0);
      add_id(ID_BITS'(14776335), 1'b0);
      add_id(ID_BITS'(14776336), 1'b0);
      add_id(ID_BITS'(916132831), 1'b0);
      add_id(ID_BITS'(916132832), 1'b0);
      add_id({ID_BITS{1'b1}}, 1'b0);
      add_id(ID_BITS'(32'h2AAA_AAAA), 1'b0);
      add_id(ID_BITS'(32'h5555_5555), 1'b0);
      add_id(ID_BITS'(1) << (ID_BITS - 1), 1'b0);
      add_id(ID_BITS'(0), 1'b0);
      for (int i = 0; i < RANDOM_IDS; i++) begin
         case ($urandom_range(0, 19))
            0:       id = '0;
            1, 2:    id = ID_BITS'($urandom_range(1, 61));
            3, 4:    id = ID_BITS'($urandom_range(62, 3843));
            5, 6:    id = ID_BITS'($urandom_range(3844, 238327));
            7, 8:    id = ID_BITS'($urandom_range(238328, 14776335));
            9, 10:   id = ID_BITS'($urandom_range(14776336, 916132831));
            11, 12:  id = ID_BITS'($urandom_range(916132832, 2147483647));
            default: id = ID_BITS'($urandom());
         endcase
         add_id(id, (i % 200) == 0);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (ids_accepted != ids_total || expected_chars.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (expected_chars.size() != 0) begin
         errors++;
         $display("%0t: %0d characters expected but never delivered",
                  $time, expected_chars.size());
      end
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
